// ===== rtl/s5h_pkg.sv =====
// ----------------------------------------------------------------------------
// s5h_pkg
// Shared types and protocol constants for the SOCKS5 client handshake block.
// ----------------------------------------------------------------------------
package s5h_pkg;

  // Input item actions
  localparam logic [1:0] ACT_LOAD  = 2'd0;
  localparam logic [1:0] ACT_START = 2'd1;
  localparam logic [1:0] ACT_RECV  = 2'd2;

  // Store selects for load items
  localparam logic [1:0] STORE_USER = 2'd0;
  localparam logic [1:0] STORE_PASS = 2'd1;
  localparam logic [1:0] STORE_ADDR = 2'd2;

  // Result kinds and status codes
  localparam logic       KIND_TX     = 1'b0;
  localparam logic       KIND_STATUS = 1'b1;
  localparam logic [1:0] ST_OPEN     = 2'd0;
  localparam logic [1:0] ST_PROTO    = 2'd1;
  localparam logic [1:0] ST_AUTH     = 2'd2;

  // Configuration register indexes
  localparam int unsigned CfgIdxW = 3;
  localparam logic [CfgIdxW-1:0] CFG_USER_LEN   = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_PASS_LEN   = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_ADDR_TYPE  = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_DOMAIN_LEN = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_DEST_PORT  = 3'd4;
  localparam int unsigned CfgDataW = 16;

  // Destination address kinds (addr_type register)
  localparam logic [1:0] AT_IPV4   = 2'd0;
  localparam logic [1:0] AT_DOMAIN = 2'd1;
  localparam logic [1:0] AT_IPV6   = 2'd2;
  localparam logic [1:0] AT_BAD    = 2'd3;

  // Wire bytes
  localparam logic [7:0] SOCKS_VER     = 8'h05;
  localparam logic [7:0] AUTH_VER      = 8'h01;
  localparam logic [7:0] METH_NONE     = 8'h00;
  localparam logic [7:0] METH_USERPASS = 8'h02;
  localparam logic [7:0] METH_ONE      = 8'h01;
  localparam logic [7:0] METH_TWO      = 8'h02;
  localparam logic [7:0] CMD_CONNECT   = 8'h01;
  localparam logic [7:0] BYTE_ZERO     = 8'h00;
  localparam logic [7:0] ATYP_IPV4     = 8'h01;
  localparam logic [7:0] ATYP_DOMAIN   = 8'h03;
  localparam logic [7:0] ATYP_IPV6     = 8'h04;

  // CONNECT reply lengths
  localparam logic [8:0] REPLY_LEN_IPV4 = 9'd10;
  localparam logic [8:0] REPLY_LEN_IPV6 = 9'd22;
  localparam logic [8:0] REPLY_LEN_DOM0 = 9'd7;

  // Address byte counts of the fixed-size kinds
  localparam int unsigned IPV4_BYTES = 4;
  localparam int unsigned IPV6_BYTES = 16;

  // Output runs the emitter can produce
  typedef enum logic [1:0] {
    RUN_GREET,
    RUN_AUTH,
    RUN_CONNECT,
    RUN_STATUS
  } run_e;

  typedef struct packed {
    logic [1:0] action;
    logic [1:0] store_select;
    logic [4:0] store_index;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] tx_byte;
    logic [1:0] status;
    logic       last;
  } out_item_t;

  typedef struct packed {
    logic [4:0]  user_len;
    logic [4:0]  pass_len;
    logic [1:0]  addr_type;
    logic [5:0]  domain_len;
    logic [15:0] dest_port;
  } cfg_t;

  // Run request from the protocol control to the emitter
  typedef struct packed {
    logic       start;
    run_e       run;
    logic [1:0] status;
  } run_req_t;

endpackage

// ===== rtl/socks5_client_handshake.sv =====
// ----------------------------------------------------------------------------
// socks5_client_handshake
// Client side of the SOCKS5 handshake with username/password subnegotiation.
// ----------------------------------------------------------------------------
// Usage:
//   Config port (cfg_valid_i/cfg_index_i/cfg_data_i) sets the credential
//   lengths, address kind, domain length and port; it is always ready. It
//   must be written only while the block is idle; the block does not enforce this.
//   Input items load store bytes, start the handshake, or hand in one byte
//   received from the server. in_ready_o is high whenever no output run is
//   being walked; loads and bytes that produce nothing leave it high.
//   An item that produces results holds the input while its run is walked:
//   the item is taken, then one result per cycle while the output is not
//   stalled. Each result passes from the run state through the staging
//   register into the output register, taking the byte store's registered
//   read data on the way. Longest run is the CONNECT request with a
//   full-length domain name.
//   A stalled output (out_ready_i low) holds the output register and the
//   staging register, which in turn pauses the run.
//   Reset returns the protocol to its initial phase and clears the config
//   registers; store contents are undefined until loaded.
// ----------------------------------------------------------------------------
module socks5_client_handshake #(
  parameter int unsigned MAX_CRED_LEN   = 16,
  parameter int unsigned MAX_DOMAIN_LEN = 32
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  s5h_pkg::in_item_t                    in_item_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output s5h_pkg::out_item_t                   out_item_o,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [s5h_pkg::CfgIdxW-1:0]          cfg_index_i,
  input  logic [s5h_pkg::CfgDataW-1:0]         cfg_data_i
);

  // Store layout: username, password, then destination address
  localparam int unsigned AddrCap   = (MAX_DOMAIN_LEN > 16) ? MAX_DOMAIN_LEN : 16;
  localparam int unsigned AddrDepth = (AddrCap > 32) ? 32 : AddrCap;
  localparam int unsigned MemDepth  = 2 * MAX_CRED_LEN + AddrDepth;
  localparam int unsigned MemAw     = $clog2(MemDepth);
  localparam int unsigned LenMax0   = (MAX_DOMAIN_LEN > MAX_CRED_LEN) ? MAX_DOMAIN_LEN
                                                                      : MAX_CRED_LEN;
  localparam int unsigned LenMax    = (LenMax0 > 16) ? LenMax0 : 16;
  localparam int unsigned CntW      = $clog2(LenMax + 1);

  // Protocol phases
  localparam logic [2:0] PH_INIT      = 3'd0;
  localparam logic [2:0] PH_GREETED   = 3'd1;
  localparam logic [2:0] PH_AUTHING   = 3'd2;
  localparam logic [2:0] PH_REQUESTED = 3'd3;
  localparam logic [2:0] PH_OPEN      = 3'd4;
  localparam logic [2:0] PH_ERROR     = 3'd5;

  logic [2:0]          phase_q, phase_d;
  logic [8:0]          rcnt_q, rcnt_d;
  logic [8:0]          rtot_q, rtot_d;
  s5h_pkg::cfg_t       cfg_q;

  logic                in_fire, busy;
  s5h_pkg::run_req_t   req;
  logic                wr_en;
  logic [MemAw-1:0]    wr_addr;
  logic                rd_en;
  logic [MemAw-1:0]    rd_addr;
  logic [7:0]          rd_data;
  logic [7:0]          rx;
  logic [8:0]          cnt_inc, tot_new;
  logic                rep_bad;

  assign in_ready_o  = !busy;
  assign in_fire     = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;
  assign rx          = in_item_i.data_byte;
  assign cnt_inc     = rcnt_q + 9'd1;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        s5h_pkg::CFG_USER_LEN:   cfg_q.user_len   <= cfg_data_i[4:0];
        s5h_pkg::CFG_PASS_LEN:   cfg_q.pass_len   <= cfg_data_i[4:0];
        s5h_pkg::CFG_ADDR_TYPE:  cfg_q.addr_type  <= cfg_data_i[1:0];
        s5h_pkg::CFG_DOMAIN_LEN: cfg_q.domain_len <= cfg_data_i[5:0];
        s5h_pkg::CFG_DEST_PORT:  cfg_q.dest_port  <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // CONNECT reply check: which byte is wrong, and the total once known
  always_comb begin
    rep_bad = 1'b0;
    tot_new = rtot_q;
    if (rcnt_q == 9'd0) begin
      rep_bad = (rx != s5h_pkg::SOCKS_VER);
    end else if (rcnt_q == 9'd1 || rcnt_q == 9'd2) begin
      rep_bad = (rx != s5h_pkg::BYTE_ZERO);
    end else if (rcnt_q == 9'd3) begin
      case (rx)
        s5h_pkg::ATYP_IPV4:   tot_new = s5h_pkg::REPLY_LEN_IPV4;
        s5h_pkg::ATYP_IPV6:   tot_new = s5h_pkg::REPLY_LEN_IPV6;
        s5h_pkg::ATYP_DOMAIN: tot_new = 9'd0;
        default:              rep_bad = 1'b1;
      endcase
    end else if (rcnt_q == 9'd4 && rtot_q == 9'd0) begin
      tot_new = s5h_pkg::REPLY_LEN_DOM0 + {1'b0, rx};
    end
  end

  // Protocol control: store writes, phase updates, run requests
  always_comb begin
    phase_d    = phase_q;
    rcnt_d     = rcnt_q;
    rtot_d     = rtot_q;
    req.start  = 1'b0;
    req.run    = s5h_pkg::RUN_STATUS;
    req.status = s5h_pkg::ST_PROTO;
    wr_en      = 1'b0;
    wr_addr    = '0;

    if (in_fire) begin
      case (in_item_i.action)
        s5h_pkg::ACT_LOAD: begin
          case (in_item_i.store_select)
            s5h_pkg::STORE_USER: begin
              wr_en   = ({1'b0, in_item_i.store_index} < 6'(MAX_CRED_LEN));
              wr_addr = MemAw'(in_item_i.store_index);
            end
            s5h_pkg::STORE_PASS: begin
              wr_en   = ({1'b0, in_item_i.store_index} < 6'(MAX_CRED_LEN));
              wr_addr = MemAw'(MAX_CRED_LEN) + MemAw'(in_item_i.store_index);
            end
            s5h_pkg::STORE_ADDR: begin
              wr_en   = ({1'b0, in_item_i.store_index} < 6'(AddrDepth));
              wr_addr = MemAw'(2 * MAX_CRED_LEN) + MemAw'(in_item_i.store_index);
            end
            default: ;
          endcase
        end
        s5h_pkg::ACT_START: begin
          req.start = 1'b1;
          if (phase_q == PH_INIT) begin
            req.run = s5h_pkg::RUN_GREET;
            phase_d = PH_GREETED;
            rcnt_d  = 9'd0;
          end
        end
        s5h_pkg::ACT_RECV: begin
          case (phase_q)
            PH_GREETED: begin
              if (rcnt_q == 9'd0) begin
                if (rx != s5h_pkg::SOCKS_VER) begin
                  req.start = 1'b1;
                  phase_d   = PH_ERROR;
                end else begin
                  rcnt_d = 9'd1;
                end
              end else if (rx == s5h_pkg::METH_NONE) begin
                req.start = 1'b1;
                if (cfg_q.addr_type == s5h_pkg::AT_BAD) begin
                  phase_d = PH_ERROR;
                end else begin
                  req.run = s5h_pkg::RUN_CONNECT;
                  phase_d = PH_REQUESTED;
                  rcnt_d  = 9'd0;
                  rtot_d  = 9'd0;
                end
              end else if (rx == s5h_pkg::METH_USERPASS && cfg_q.user_len != 5'd0) begin
                req.start = 1'b1;
                req.run   = s5h_pkg::RUN_AUTH;
                phase_d   = PH_AUTHING;
                rcnt_d    = 9'd0;
              end else begin
                req.start  = 1'b1;
                req.status = s5h_pkg::ST_AUTH;
                phase_d    = PH_ERROR;
              end
            end
            PH_AUTHING: begin
              if (rcnt_q == 9'd0) begin
                if (rx != s5h_pkg::AUTH_VER) begin
                  req.start = 1'b1;
                  phase_d   = PH_ERROR;
                end else begin
                  rcnt_d = 9'd1;
                end
              end else if (rx != s5h_pkg::BYTE_ZERO) begin
                req.start  = 1'b1;
                req.status = s5h_pkg::ST_AUTH;
                phase_d    = PH_ERROR;
              end else begin
                req.start = 1'b1;
                if (cfg_q.addr_type == s5h_pkg::AT_BAD) begin
                  phase_d = PH_ERROR;
                end else begin
                  req.run = s5h_pkg::RUN_CONNECT;
                  phase_d = PH_REQUESTED;
                  rcnt_d  = 9'd0;
                  rtot_d  = 9'd0;
                end
              end
            end
            PH_REQUESTED: begin
              if (rep_bad) begin
                req.start = 1'b1;
                phase_d   = PH_ERROR;
              end else begin
                rcnt_d = cnt_inc;
                rtot_d = tot_new;
                if (tot_new != 9'd0 && cnt_inc >= tot_new) begin
                  req.start  = 1'b1;
                  req.status = s5h_pkg::ST_OPEN;
                  phase_d    = PH_OPEN;
                end
              end
            end
            default: req.start = 1'b1;
          endcase
        end
        default: ;
      endcase
    end
  end

  // Protocol state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_INIT;
      rcnt_q  <= 9'd0;
      rtot_q  <= 9'd0;
    end else begin
      phase_q <= phase_d;
      rcnt_q  <= rcnt_d;
      rtot_q  <= rtot_d;
    end
  end

  s5h_store_mem #(
    .Depth (MemDepth),
    .Aw    (MemAw)
  ) u_store (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (in_item_i.data_byte),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  s5h_emitter #(
    .MaxCredLen   (MAX_CRED_LEN),
    .MaxDomainLen (MAX_DOMAIN_LEN),
    .AddrDepth    (AddrDepth),
    .CntW         (CntW),
    .MemAw        (MemAw)
  ) u_emitter (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req),
    .cfg_i       (cfg_q),
    .busy_o      (busy),
    .rd_en_o     (rd_en),
    .rd_addr_o   (rd_addr),
    .rd_data_i   (rd_data),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

endmodule

// ===== rtl/s5h_store_mem.sv =====
// ----------------------------------------------------------------------------
// s5h_store_mem
// Byte store for username, password and destination address: one write port,
// one read port with registered read data.
// ----------------------------------------------------------------------------
module s5h_store_mem #(
  parameter int unsigned Depth = 64,
  parameter int unsigned Aw    = 6
) (
  input  logic          clk_i,
  input  logic          wr_en_i,
  input  logic [Aw-1:0] wr_addr_i,
  input  logic [7:0]    wr_data_i,
  input  logic          rd_en_i,
  input  logic [Aw-1:0] rd_addr_i,
  output logic [7:0]    rd_data_o
);

  logic [7:0] mem_q [Depth];
  logic [7:0] rd_data_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Read port, data held until the next read
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== rtl/s5h_emitter.sv =====
// ----------------------------------------------------------------------------
// s5h_emitter
// Walks one output run (greeting, auth request, CONNECT request or status)
// a byte per cycle while the output is not stalled, reading store bytes through
// the memory and passing them through a staging register into the output register.
// ----------------------------------------------------------------------------
module s5h_emitter #(
  parameter int unsigned MaxCredLen   = 16,
  parameter int unsigned MaxDomainLen = 32,
  parameter int unsigned AddrDepth    = 32,
  parameter int unsigned CntW         = 6,
  parameter int unsigned MemAw        = 7
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  s5h_pkg::run_req_t    req_i,
  input  s5h_pkg::cfg_t        cfg_i,
  output logic                 busy_o,
  output logic                 rd_en_o,
  output logic [MemAw-1:0]     rd_addr_o,
  input  logic [7:0]           rd_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output s5h_pkg::out_item_t   out_item_o
);

  localparam int unsigned AddrIdxW = $clog2(AddrDepth);

  // Segment codes
  localparam logic [3:0] SG_IDLE      = 4'd0;
  localparam logic [3:0] SG_GREET     = 4'd1;
  localparam logic [3:0] SG_STATUS    = 4'd2;
  localparam logic [3:0] SG_AUTH_VER  = 4'd3;
  localparam logic [3:0] SG_AUTH_ULEN = 4'd4;
  localparam logic [3:0] SG_AUTH_USER = 4'd5;
  localparam logic [3:0] SG_AUTH_PLEN = 4'd6;
  localparam logic [3:0] SG_AUTH_PASS = 4'd7;
  localparam logic [3:0] SG_CONN_HDR  = 4'd8;
  localparam logic [3:0] SG_CONN_DLEN = 4'd9;
  localparam logic [3:0] SG_CONN_ADDR = 4'd10;
  localparam logic [3:0] SG_CONN_PHI  = 4'd11;
  localparam logic [3:0] SG_CONN_PLO  = 4'd12;

  logic [3:0]          seg_q, seg_d;
  logic [CntW-1:0]     idx_q, idx_d;
  logic [1:0]          stat_q, stat_d;
  logic [CntW-1:0]     idx_inc;

  logic                p1_valid_q, p1_valid_d;
  s5h_pkg::out_item_t  p1_q;
  logic                p1_mem_q;
  s5h_pkg::out_item_t  p1_out;
  logic                out_valid_q, out_valid_d;
  s5h_pkg::out_item_t  out_q;

  logic                issue, p1_adv;
  s5h_pkg::out_item_t  desc;
  logic                desc_mem;
  logic [MemAw-1:0]    desc_addr;

  logic [CntW-1:0]     ulen, plen, dlen, acnt;
  logic                greet_long;
  logic [7:0]          atyp;

  // Saturated lengths and per-kind address counts
  always_comb begin
    ulen = (cfg_i.user_len > 5'(MaxCredLen)) ? CntW'(MaxCredLen) : CntW'(cfg_i.user_len);
    plen = (cfg_i.pass_len > 5'(MaxCredLen)) ? CntW'(MaxCredLen) : CntW'(cfg_i.pass_len);
    dlen = (cfg_i.domain_len > 6'(MaxDomainLen)) ? CntW'(MaxDomainLen)
                                                   : CntW'(cfg_i.domain_len);
    case (cfg_i.addr_type)
      s5h_pkg::AT_IPV4: begin
        acnt = CntW'(s5h_pkg::IPV4_BYTES);
        atyp = s5h_pkg::ATYP_IPV4;
      end
      s5h_pkg::AT_DOMAIN: begin
        acnt = dlen;
        atyp = s5h_pkg::ATYP_DOMAIN;
      end
      default: begin
        acnt = CntW'(s5h_pkg::IPV6_BYTES);
        atyp = s5h_pkg::ATYP_IPV6;
      end
    endcase
    greet_long = (cfg_i.user_len != 5'd0);
  end

  assign idx_inc = idx_q + CntW'(1);

  // Staging moves on when the output register is free or being drained
  assign p1_adv = p1_valid_q && (!out_valid_q || out_ready_i);
  assign issue  = (seg_q != SG_IDLE) && (!p1_valid_q || p1_adv);

  // Current item and next position in the run
  always_comb begin
    desc         = '0;
    desc.kind    = s5h_pkg::KIND_TX;
    desc.status  = s5h_pkg::ST_OPEN;
    desc_mem     = 1'b0;
    desc_addr    = '0;
    seg_d        = seg_q;
    idx_d        = idx_q;
    stat_d       = stat_q;

    if (req_i.start) begin
      idx_d  = '0;
      stat_d = req_i.status;
      case (req_i.run)
        s5h_pkg::RUN_GREET:   seg_d = SG_GREET;
        s5h_pkg::RUN_AUTH:    seg_d = SG_AUTH_VER;
        s5h_pkg::RUN_CONNECT: seg_d = SG_CONN_HDR;
        default:              seg_d = SG_STATUS;
      endcase
    end else if (issue) begin
      case (seg_q)
        SG_GREET: begin
          case (idx_q[1:0])
            2'd0:    desc.tx_byte = s5h_pkg::SOCKS_VER;
            2'd1:    desc.tx_byte = greet_long ? s5h_pkg::METH_TWO : s5h_pkg::METH_ONE;
            2'd2:    desc.tx_byte = s5h_pkg::METH_NONE;
            default: desc.tx_byte = s5h_pkg::METH_USERPASS;
          endcase
          desc.last = greet_long ? (idx_q[1:0] == 2'd3) : (idx_q[1:0] == 2'd2);
          idx_d     = idx_inc;
          if (desc.last) seg_d = SG_IDLE;
        end
        SG_STATUS: begin
          desc.kind   = s5h_pkg::KIND_STATUS;
          desc.status = stat_q;
          desc.last   = 1'b1;
          seg_d       = SG_IDLE;
        end
        SG_AUTH_VER: begin
          desc.tx_byte = s5h_pkg::AUTH_VER;
          seg_d        = SG_AUTH_ULEN;
        end
        SG_AUTH_ULEN: begin
          desc.tx_byte = 8'(ulen);
          idx_d        = '0;
          seg_d        = (ulen == '0) ? SG_AUTH_PLEN : SG_AUTH_USER;
        end
        SG_AUTH_USER: begin
          desc_mem  = 1'b1;
          desc_addr = MemAw'(idx_q);
          idx_d     = idx_inc;
          if (idx_inc == ulen) seg_d = SG_AUTH_PLEN;
        end
        SG_AUTH_PLEN: begin
          desc.tx_byte = 8'(plen);
          desc.last    = (plen == '0);
          idx_d        = '0;
          seg_d        = (plen == '0) ? SG_IDLE : SG_AUTH_PASS;
        end
        SG_AUTH_PASS: begin
          desc_mem  = 1'b1;
          desc_addr = MemAw'(MaxCredLen) + MemAw'(idx_q);
          desc.last = (idx_inc == plen);
          idx_d     = idx_inc;
          if (desc.last) seg_d = SG_IDLE;
        end
        SG_CONN_HDR: begin
          case (idx_q[1:0])
            2'd0:    desc.tx_byte = s5h_pkg::SOCKS_VER;
            2'd1:    desc.tx_byte = s5h_pkg::CMD_CONNECT;
            2'd2:    desc.tx_byte = s5h_pkg::BYTE_ZERO;
            default: desc.tx_byte = atyp;
          endcase
          idx_d = idx_inc;
          if (idx_q[1:0] == 2'd3) begin
            idx_d = '0;
            if (cfg_i.addr_type == s5h_pkg::AT_DOMAIN) seg_d = SG_CONN_DLEN;
            else seg_d = (acnt == '0) ? SG_CONN_PHI : SG_CONN_ADDR;
          end
        end
        SG_CONN_DLEN: begin
          desc.tx_byte = 8'(dlen);
          idx_d        = '0;
          seg_d        = (acnt == '0) ? SG_CONN_PHI : SG_CONN_ADDR;
        end
        SG_CONN_ADDR: begin
          desc_mem  = 1'b1;
          desc_addr = MemAw'(2 * MaxCredLen) + MemAw'(idx_q[AddrIdxW-1:0]);
          idx_d     = idx_inc;
          if (idx_inc == acnt) seg_d = SG_CONN_PHI;
        end
        SG_CONN_PHI: begin
          desc.tx_byte = cfg_i.dest_port[15:8];
          seg_d        = SG_CONN_PLO;
        end
        SG_CONN_PLO: begin
          desc.tx_byte = cfg_i.dest_port[7:0];
          desc.last    = 1'b1;
          seg_d        = SG_IDLE;
        end
        default: seg_d = SG_IDLE;
      endcase
    end
  end

  // Memory read is issued together with the staging load
  assign rd_en_o   = issue && desc_mem;
  assign rd_addr_o = desc_addr;

  assign p1_valid_d  = issue ? 1'b1 : (p1_adv ? 1'b0 : p1_valid_q);
  assign out_valid_d = p1_adv ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);

  // Staged item with its store byte filled in
  always_comb begin
    p1_out = p1_q;
    if (p1_mem_q) p1_out.tx_byte = rd_data_i;
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seg_q       <= SG_IDLE;
      idx_q       <= '0;
      stat_q      <= s5h_pkg::ST_OPEN;
      p1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      seg_q       <= seg_d;
      idx_q       <= idx_d;
      stat_q      <= stat_d;
      p1_valid_q  <= p1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload: staging and output registers
  always_ff @(posedge clk_i) begin
    if (issue) begin
      p1_q     <= desc;
      p1_mem_q <= desc_mem;
    end
    if (p1_adv) begin
      out_q <= p1_out;
    end
  end

  assign busy_o      = (seg_q != SG_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

// ===== rtl/s5h_port_checker.sv =====
// ----------------------------------------------------------------------------
// s5h_port_checker
// Port-level checks for the SOCKS5 client handshake block, bound to the top.
// ----------------------------------------------------------------------------
module s5h_port_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input s5h_pkg::in_item_t  in_item_i,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input s5h_pkg::out_item_t out_item_o
);

  // A stalled result holds its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_item_o))
    else $error("output payload changed while stalled");

  // Status events carry no byte and always close their run
  a_status_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.kind == s5h_pkg::KIND_STATUS
      |-> out_item_o.tx_byte == 8'h00 && out_item_o.last)
    else $error("status event with byte or without last");

  // Transmit items carry a zero status
  a_tx_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.kind == s5h_pkg::KIND_TX
      |-> out_item_o.status == s5h_pkg::ST_OPEN)
    else $error("transmit item with nonzero status");

  // A start always yields a run, so input closes right after it
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && in_item_i.action == s5h_pkg::ACT_START
      |=> !in_ready_o)
    else $error("input still open after start transfer");

endmodule

bind socks5_client_handshake s5h_port_checker u_port_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_item_i   (in_item_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_item_o  (out_item_o)
);
